@@ src/sltab_pkg.sv @@
`default_nettype none

package sltab_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [2:0] status_t;

  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_PUSH   = 2'd2;
  localparam cmd_t CMD_UPDATE = 2'd3;

  localparam status_t ST_CLEARED  = 3'd0;
  localparam status_t ST_INSERTED = 3'd1;
  localparam status_t ST_TAKEN    = 3'd2;
  localparam status_t ST_INVALID  = 3'd3;
  localparam status_t ST_PUSHED   = 3'd4;
  localparam status_t ST_FULL     = 3'd5;
  localparam status_t ST_UPDATED  = 3'd6;

  localparam int PosW   = 6;
  localparam int SizeW  = 7;
  localparam int ValueW = 32;
  localparam int GroupW = 8;
  localparam int LocW   = 3;

  localparam logic [SizeW-1:0] SizeReset = 7'd64;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

@@ src/slot_table_first_free_insert.sv @@
// Slot table with first-free allocation. A command is taken when start is high and busy is
// low; its result is registered onto status_o and slot_used_o at the end of the execute state,
// marked by result_valid_o high for exactly one cycle, and cannot be held off.
// Each command registers the per-group first-free search over the occupancy bits, then in
// the execute state resolves the winning group and updates the table, so busy is high only in
// the execute state after acceptance and a new command may be started while a result is shown.
// The table keeps one occupancy bit per slot, so clear takes effect at once with no sweep.
// size_in_use may only be written while no command is in flight.
`default_nettype none

module slot_table_first_free_insert
  import sltab_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command_i,
  input  logic [PosW-1:0]          position_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic                     size_in_use_we_i,
  input  logic [SizeW-1:0]         size_in_use_i,
  output logic                     result_valid_o,
  output logic [2:0]               status_o,
  output logic [PosW-1:0]          slot_used_o
);

  dp_cmd_t dp_cmd;

  sltab_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .dp_cmd_o       (dp_cmd),
    .result_valid_o (result_valid_o)
  );

  sltab_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dp_cmd_i    (dp_cmd),
    .command_i   (command_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .size_we_i   (size_in_use_we_i),
    .size_i      (size_in_use_i),
    .status_o    (status_o),
    .slot_used_o (slot_used_o)
  );

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o && !busy)
    else $error("result beat did not follow the execute cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat overlaps a busy cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == ST_CLEARED || status_o == ST_TAKEN ||
                       status_o == ST_INVALID || status_o == ST_FULL)
      |-> slot_used_o == '0)
    else $error("slot index reported for a command that wrote nothing");
`endif

endmodule

`default_nettype wire

@@ src/sltab_ctrl.sv @@
`default_nettype none

module sltab_ctrl
  import sltab_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  output dp_cmd_t dp_cmd_o,
  output logic    result_valid_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic result_valid_q, result_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign dp_cmd_o.load  = (state_q == StIdle) && start_i;
  assign dp_cmd_o.exec  = (state_q == StExec);
  assign result_valid_d = (state_q == StExec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
    end
  end

  assign busy_o         = (state_q == StExec);
  assign result_valid_o = result_valid_q;

endmodule

`default_nettype wire

@@ src/sltab_dp.sv @@
`default_nettype none

module sltab_dp
  import sltab_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           dp_cmd_i,
  input  cmd_t              command_i,
  input  logic [PosW-1:0]   position_i,
  input  logic [ValueW-1:0] value_i,
  input  logic              size_we_i,
  input  logic [SizeW-1:0]  size_i,
  output status_t           status_o,
  output logic [PosW-1:0]   slot_used_o
);

  localparam int NumGrp  = (SLOT_COUNT + GroupW - 1) / GroupW;
  localparam int PadW    = NumGrp * GroupW;
  localparam int GrpIdxW = (NumGrp > 1) ? $clog2(NumGrp) : 1;
  localparam int FoundW  = GrpIdxW + LocW;

  // One occupancy bit per slot: a slot is occupied exactly when the last value written to it was non-zero.
  logic [PadW-1:0]  occ_q, occ_d;
  logic [SizeW-1:0] size_q;
  cmd_t             cmd_q;
  logic [PosW-1:0]  pos_q;
  logic             val_nz_q;
  status_t          status_q, status_d;
  logic [PosW-1:0]  slot_used_q, slot_used_d;

  logic [PadW-1:0]   free_c;
  logic [NumGrp-1:0] grp_any_d, grp_any_q;
  logic [LocW-1:0]   grp_loc_d [NumGrp];
  logic [LocW-1:0]   grp_loc_q [NumGrp];

  logic              found_any;
  logic [FoundW-1:0] found_idx;
  logic              pos_valid;
  logic              pos_taken;

  always_comb begin
    for (int i = 0; i < PadW; i++) begin
      free_c[i] = !occ_q[i] && (i < SLOT_COUNT) && (i < int'(size_q));
    end
  end

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_any_d[g] = |free_c[g*GroupW +: GroupW];
      grp_loc_d[g] = '0;
      for (int j = GroupW - 1; j >= 0; j--) begin
        if (free_c[g*GroupW + j]) begin
          grp_loc_d[g] = LocW'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    for (int g = 0; g < NumGrp; g++) begin
      grp_loc_q[g] <= grp_loc_d[g];
    end
  end

  always_comb begin
    found_any = 1'b0;
    found_idx = '0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found_any = 1'b1;
        found_idx = {GrpIdxW'(g), grp_loc_q[g]};
      end
    end
  end

  always_comb begin
    pos_taken = 1'b0;
    for (int i = 0; i < PadW; i++) begin
      if (int'(pos_q) == i) begin
        pos_taken = occ_q[i];
      end
    end
  end

  assign pos_valid = (int'(pos_q) < SLOT_COUNT) && ({1'b0, pos_q} < size_q);

  always_comb begin
    occ_d       = occ_q;
    status_d    = status_q;
    slot_used_d = slot_used_q;
    if (dp_cmd_i.exec) begin
      case (cmd_q)
        CMD_CLEAR: begin
          occ_d       = '0;
          status_d    = ST_CLEARED;
          slot_used_d = '0;
        end
        CMD_INSERT: begin
          slot_used_d = '0;
          if (!pos_valid) begin
            status_d = ST_INVALID;
          end else if (pos_taken) begin
            status_d = ST_TAKEN;
          end else begin
            for (int i = 0; i < PadW; i++) begin
              if (int'(pos_q) == i) begin
                occ_d[i] = val_nz_q;
              end
            end
            status_d    = ST_INSERTED;
            slot_used_d = pos_q;
          end
        end
        CMD_PUSH: begin
          slot_used_d = '0;
          status_d    = ST_FULL;
          if (found_any) begin
            for (int i = 0; i < PadW; i++) begin
              if (int'(found_idx) == i) begin
                occ_d[i] = val_nz_q;
              end
            end
            status_d    = ST_PUSHED;
            slot_used_d = PosW'(found_idx);
          end
        end
        default: begin
          slot_used_d = '0;
          if (!pos_valid) begin
            status_d = ST_INVALID;
          end else begin
            for (int i = 0; i < PadW; i++) begin
              if (int'(pos_q) == i) begin
                occ_d[i] = val_nz_q;
              end
            end
            status_d    = ST_UPDATED;
            slot_used_d = pos_q;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      size_q <= SizeReset;
    end else begin
      occ_q <= occ_d;
      if (size_we_i) begin
        size_q <= size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      cmd_q    <= command_i;
      pos_q    <= position_i;
      val_nz_q <= |value_i;
    end
    status_q    <= status_d;
    slot_used_q <= slot_used_d;
  end

  assign status_o    = status_q;
  assign slot_used_o = slot_used_q;

endmodule

`default_nettype wire

@@ test/slot_table_first_free_insert_tb.sv @@
`default_nettype none

module slot_table_first_free_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sltab_pkg::*;

  localparam int SLOTS = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int SHOWN_ERRORS = 10;
  localparam int BLOCK_ITEMS = 50;

  typedef struct packed {
    status_t           status;
    logic [PosW-1:0]   slot;
  } table_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  cmd_t                     command_i;
  logic [PosW-1:0]          position_i;
  logic signed [ValueW-1:0] value_i;
  logic                     size_in_use_we_i;
  logic [SizeW-1:0]         size_in_use_i;
  logic                     result_valid_o;
  logic [2:0]               status_o;
  logic [PosW-1:0]          slot_used_o;

  table_result_t            expected_results[$];
  table_result_t            oldest_result;
  logic signed [ValueW-1:0] slot_mirror [SLOTS];
  logic [SizeW-1:0]         size_mirror;
  int                       error_count;
  int                       quiet_cycles;
  int                       sender_idle_pct;

  slot_table_first_free_insert #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .size_in_use_we_i(size_in_use_we_i),
    .size_in_use_i   (size_in_use_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .slot_used_o     (slot_used_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned search_limit();
    return (size_mirror > SLOTS) ? SLOTS : int'(size_mirror);
  endfunction

  function automatic table_result_t apply_command(input cmd_t c, input logic [PosW-1:0] p,
                                                  input logic signed [ValueW-1:0] v);
    table_result_t r;
    int unsigned   lim;
    bit            found;
    lim = search_limit();
    found = 1'b0;
    r.slot = '0;
    case (c)
      CMD_CLEAR: begin
        foreach (slot_mirror[i]) slot_mirror[i] = '0;
        r.status = ST_CLEARED;
      end
      CMD_INSERT: begin
        if (p >= lim) begin
          r.status = ST_INVALID;
        end else if (slot_mirror[p] == 0) begin
          slot_mirror[p] = v;
          r.status = ST_INSERTED;
          r.slot = p;
        end else begin
          r.status = ST_TAKEN;
        end
      end
      CMD_PUSH: begin
        r.status = ST_FULL;
        for (int i = 0; i < lim; i++) begin
          if (!found && slot_mirror[i] == 0) begin
            found = 1'b1;
            slot_mirror[i] = v;
            r.status = ST_PUSHED;
            r.slot = i[PosW-1:0];
          end
        end
      end
      default: begin
        if (p >= lim) begin
          r.status = ST_INVALID;
        end else begin
          slot_mirror[p] = v;
          r.status = ST_UPDATED;
          r.slot = p;
        end
      end
    endcase
    return r;
  endfunction

  // Each call starts at a rising edge and returns at the edge that accepted the beat,
  // with start left high so that back-to-back commands need no second assignment.
  task automatic send_item(input cmd_t c, input logic [PosW-1:0] p,
                           input logic signed [ValueW-1:0] v);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start      <= 1'b1;
    command_i  <= c;
    position_i <= p;
    value_i    <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_results.push_back(apply_command(c, p, v));
  endtask

  task automatic set_size_in_use(input logic [SizeW-1:0] s);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    size_in_use_we_i <= 1'b1;
    size_in_use_i    <= s;
    @(posedge clk_i);
    size_in_use_we_i <= 1'b0;
    size_mirror = s;
  endtask

  task automatic send_random_item();
    cmd_t                     c;
    logic [PosW-1:0]          p;
    logic signed [ValueW-1:0] v;
    int                       roll;
    int unsigned              lim;
    lim = search_limit();
    roll = $urandom_range(0, 99);
    if (roll < 4) c = CMD_CLEAR;
    else if (roll < 34) c = CMD_INSERT;
    else if (roll < 70) c = CMD_PUSH;
    else c = CMD_UPDATE;
    if (lim != 0 && $urandom_range(0, 99) < 85) p = PosW'($urandom_range(0, lim - 1));
    else p = PosW'($urandom_range(0, SLOTS - 1));
    roll = $urandom_range(0, 99);
    if (roll < 10) v = '0;
    else if (roll < 13) v = 32'sh7fffffff;
    else if (roll < 16) v = 32'sh80000000;
    else v = $urandom;
    send_item(c, p, v);
  endtask

  function automatic logic [SizeW-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return SizeW'($urandom_range(1, 16));
    else if (roll < 80) return SizeW'(SLOTS);
    else if (roll < 90) return SizeW'($urandom_range(SLOTS + 1, 127));
    else if (roll < 95) return '0;
    else return SizeW'($urandom_range(17, SLOTS - 1));
  endfunction

  task automatic test_insert_update();
    send_item(CMD_PUSH, 6'd0, 32'sd17);
    send_item(CMD_INSERT, 6'd0, 32'sd5);
    send_item(CMD_INSERT, 6'd63, 32'sh7fffffff);
    send_item(CMD_INSERT, 6'd63, 32'sd1);
    send_item(CMD_UPDATE, 6'd63, 32'sh80000000);
    send_item(CMD_UPDATE, 6'd63, 32'sd0);
    send_item(CMD_INSERT, 6'd63, -32'sd1);
    send_item(CMD_UPDATE, 6'd42, 32'sd0);
  endtask

  task automatic test_push_full();
    send_item(CMD_PUSH, 6'd63, 32'sd0);
    send_item(CMD_PUSH, 6'd0, -32'sd5);
    set_size_in_use(7'd2);
    send_item(CMD_PUSH, 6'd21, 32'sd9);
    send_item(CMD_INSERT, 6'd2, 32'sd9);
    send_item(CMD_UPDATE, 6'd63, 32'sd9);
    send_item(CMD_CLEAR, 6'd63, 32'shffffffff);
    set_size_in_use(7'd64);
    send_item(CMD_INSERT, 6'd63, 32'sd3);
  endtask

  task automatic test_size_limits();
    set_size_in_use(7'd0);
    send_item(CMD_PUSH, 6'd0, 32'sd1);
    send_item(CMD_INSERT, 6'd0, 32'sd1);
    send_item(CMD_UPDATE, 6'd0, 32'sd1);
    set_size_in_use(7'd127);
    send_item(CMD_INSERT, 6'd63, 32'sd4);
    send_item(CMD_UPDATE, 6'd63, 32'sd8);
    send_item(CMD_PUSH, 6'd42, 32'sd12);
    set_size_in_use(7'd1);
    send_item(CMD_INSERT, 6'd1, 32'sd2);
    send_item(CMD_PUSH, 6'd0, 32'sd2);
    send_item(CMD_CLEAR, 6'd0, 32'sd0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int count);
    sender_idle_pct = idle_pct;
    for (int done = 0; done < count; done += BLOCK_ITEMS) begin
      set_size_in_use(pick_size());
      repeat (BLOCK_ITEMS) send_random_item();
    end
    sender_idle_pct = 0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS)
          $display("unexpected result: status %0d slot %0d", status_o, slot_used_o);
      end else begin
        oldest_result = expected_results.pop_front();
        if (status_o !== oldest_result.status || slot_used_o !== oldest_result.slot) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS)
            $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     oldest_result.status, oldest_result.slot, status_o, slot_used_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || result_valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    command_i        = CMD_CLEAR;
    position_i       = '0;
    value_i          = '0;
    size_in_use_we_i = 1'b0;
    size_in_use_i    = SizeReset;
    size_mirror      = SizeReset;
    error_count      = 0;
    quiet_cycles     = 0;
    sender_idle_pct  = 0;
    foreach (slot_mirror[i]) slot_mirror[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_insert_update();
    test_push_full();
    test_size_limits();
    test_random_traffic(22, 400);
    test_random_traffic(59, 400);
    test_random_traffic(0, 400);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ slot_table_first_free_insert.f @@
src/sltab_pkg.sv
src/sltab_ctrl.sv
src/sltab_dp.sv
src/slot_table_first_free_insert.sv
test/slot_table_first_free_insert_tb.sv
